// File: rtl/iokt_pkg.sv
// Package: types, codes and defaults for the insertion-ordered key table.
`timescale 1ns / 1ps

package iokt_pkg;

  // Default number of entries
  localparam int CAPACITY_DEF = 16;

  // Operation codes
  localparam logic [2:0] OP_PUT    = 3'd0;
  localparam logic [2:0] OP_DELETE = 3'd1;
  localparam logic [2:0] OP_CLEAR  = 3'd2;
  localparam logic [2:0] OP_START  = 3'd3;
  localparam logic [2:0] OP_NEXT   = 3'd4;

  // Result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_DUP     = 2'd1;
  localparam logic [1:0] ST_MISSING = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  // Input beat
  typedef struct packed {
    logic [2:0]         opcode;
    logic signed [31:0] key;
    logic signed [31:0] value;
  } in_item_t;

  // Result beat
  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] out_value;
    logic               iter_done;
    logic               table_empty;
  } out_item_t;

endpackage

// File: rtl/insertion_ordered_key_table.sv
// Insertion-ordered key table: sequencer over one key/value memory with one key comparator.
// Steps: clear, iterator ops on a done/empty table and unused codes go straight to the
//   response step; iterator ops that report a value first read the entry at the cursor;
//   put/delete read and compare each entry in turn, and a delete then moves each later entry down.
// Throughput: one beat at a time; the next beat is taken once the result is registered.
// Reset: rst_n (sync, active low) clears count, cursor and handshake state and sets the done flag;
//   the key/value memory is not cleared, only entries below the count are ever used.
`timescale 1ns / 1ps

module insertion_ordered_key_table #(
  parameter int CAPACITY = iokt_pkg::CAPACITY_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  iokt_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output iokt_pkg::out_item_t out_data
);

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = IW + 1;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_RD    = 6'b000010,
    S_CMP   = 6'b000100,
    S_MV_RD = 6'b001000,
    S_MV_WR = 6'b010000,
    S_RESP  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  // Item and entry state
  logic [2:0]         op_r, op_nxt;
  logic signed [31:0] key_r, key_nxt;
  logic signed [31:0] val_r, val_nxt;
  logic [IW-1:0]      idx_r, idx_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  logic [CW-1:0]      cursor_r, cursor_nxt;
  logic               done_r, done_nxt;
  logic [1:0]         res_status_r, res_status_nxt;
  logic signed [31:0] res_val_r, res_val_nxt;
  logic               out_valid_r, out_valid_nxt;
  iokt_pkg::out_item_t out_data_r, out_data_nxt;

  // Memory ports
  logic signed [31:0] key_mem [CAPACITY];
  logic signed [31:0] val_mem [CAPACITY];
  logic signed [31:0] key_rd_r, val_rd_r;
  logic               wr_en;
  logic [IW-1:0]      wr_addr;
  logic signed [31:0] wr_key, wr_val;

  logic [CW-1:0] idx_inc;
  logic [CW-1:0] cursor_inc;
  logic          in_fire;

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign idx_inc   = {1'b0, idx_r} + CW'(1);
  assign cursor_inc = (cursor_r < CW'(CAPACITY)) ? (cursor_r + CW'(1)) : cursor_r;

  // Memory: one write port, one registered read port at the scan index
  always_ff @(posedge clk) begin
    if (wr_en) begin
      key_mem[wr_addr] <= wr_key;
      val_mem[wr_addr] <= wr_val;
    end
    key_rd_r <= key_mem[idx_r];
    val_rd_r <= val_mem[idx_r];
  end

  // Sequencer
  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    key_nxt        = key_r;
    val_nxt        = val_r;
    idx_nxt        = idx_r;
    count_nxt      = count_r;
    cursor_nxt     = cursor_r;
    done_nxt       = done_r;
    res_status_nxt = res_status_r;
    res_val_nxt    = res_val_r;
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    wr_en          = 1'b0;
    wr_addr        = idx_r;
    wr_key         = key_rd_r;
    wr_val         = val_rd_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          op_nxt         = in_data.opcode;
          key_nxt        = in_data.key;
          val_nxt        = in_data.value;
          idx_nxt        = '0;
          res_status_nxt = iokt_pkg::ST_OK;
          res_val_nxt    = '0;
          state_nxt      = S_RESP;
          if (in_data.opcode == iokt_pkg::OP_PUT) begin
            if (count_r != '0) begin
              state_nxt = S_RD;
            end else begin
              // empty table: append at once
              wr_en     = 1'b1;
              wr_addr   = '0;
              wr_key    = in_data.key;
              wr_val    = in_data.value;
              count_nxt = count_r + CW'(1);
            end
          end else if (in_data.opcode == iokt_pkg::OP_DELETE) begin
            if (count_r != '0) begin
              state_nxt = S_RD;
            end else begin
              res_status_nxt = iokt_pkg::ST_MISSING;
            end
          end else if (in_data.opcode == iokt_pkg::OP_CLEAR) begin
            count_nxt  = '0;
            cursor_nxt = '0;
            done_nxt   = 1'b1;
          end else if (in_data.opcode == iokt_pkg::OP_START) begin
            cursor_nxt = '0;
            done_nxt   = (count_r == '0);
            if (count_r != '0) begin
              state_nxt = S_RD;
            end
          end else if (in_data.opcode == iokt_pkg::OP_NEXT) begin
            if (!done_r) begin
              cursor_nxt = cursor_inc;
              done_nxt   = (cursor_inc >= count_r);
              if (cursor_inc < count_r) begin
                idx_nxt   = cursor_inc[IW-1:0];
                state_nxt = S_RD;
              end
            end
          end
        end
      end

      S_RD: begin
        state_nxt = S_CMP;
      end

      S_CMP: begin
        state_nxt = S_RESP;
        if (op_r == iokt_pkg::OP_START || op_r == iokt_pkg::OP_NEXT) begin
          res_val_nxt = val_rd_r;
        end else if (key_rd_r == key_r) begin
          // key hit
          if (op_r == iokt_pkg::OP_PUT) begin
            res_status_nxt = iokt_pkg::ST_DUP;
          end else begin
            res_val_nxt = val_rd_r;
            if (idx_inc < count_r) begin
              idx_nxt   = idx_inc[IW-1:0];
              state_nxt = S_MV_RD;
            end else begin
              count_nxt = count_r - CW'(1);
            end
          end
        end else if (idx_inc < count_r) begin
          idx_nxt   = idx_inc[IW-1:0];
          state_nxt = S_RD;
        end else if (op_r == iokt_pkg::OP_PUT) begin
          // miss over the whole table
          if (count_r >= CW'(CAPACITY)) begin
            res_status_nxt = iokt_pkg::ST_FULL;
          end else begin
            wr_en     = 1'b1;
            wr_addr   = count_r[IW-1:0];
            wr_key    = key_r;
            wr_val    = val_r;
            count_nxt = count_r + CW'(1);
          end
        end else begin
          res_status_nxt = iokt_pkg::ST_MISSING;
        end
      end

      S_MV_RD: begin
        state_nxt = S_MV_WR;
      end

      // Move the entry at idx down by one
      S_MV_WR: begin
        wr_en   = 1'b1;
        wr_addr = idx_r - IW'(1);
        if (idx_inc < count_r) begin
          idx_nxt   = idx_inc[IW-1:0];
          state_nxt = S_MV_RD;
        end else begin
          count_nxt = count_r - CW'(1);
          state_nxt = S_RESP;
        end
      end

      S_RESP: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt          = 1'b1;
          out_data_nxt.status    = res_status_r;
          out_data_nxt.out_value = res_val_r;
          out_data_nxt.iter_done = done_r;
          out_data_nxt.table_empty = (count_r == '0);
          state_nxt              = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      cursor_r    <= '0;
      done_r      <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      cursor_r    <= cursor_nxt;
      done_r      <= done_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    key_r        <= key_nxt;
    val_r        <= val_nxt;
    idx_r        <= idx_nxt;
    res_status_r <= res_status_nxt;
    res_val_r    <= res_val_nxt;
    out_data_r   <= out_data_nxt;
  end

`ifndef SYNTHESIS
  // One beat at a time
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_ready)
    else $error("input taken while an item is in progress");

  // Count never passes capacity
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("entry count above capacity");

  // A result only appears out of the response step
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_RESP))
    else $error("result raised outside response step");

  // Writes only at or below the current count
  a_write_bound: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> ({1'b0, wr_addr} <= count_r))
    else $error("memory write beyond the filled region");
`endif

endmodule
